// ----- design/djq_pkg.sv -----
// package for the deadline sorted job queue
// request kinds, payload words, cell chain bundle and controller states; no dependencies
`timescale 1ns / 1ps

package djq_pkg;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_CHECK  = 2'd1,
		REQ_EXEC   = 2'd2,
		REQ_REMOVE = 2'd3
	} req_kind_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [7:0]  job_id;
		logic [31:0] start_limit;
		logic [31:0] now_time;
	} req_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] out_job;
		logic       overflow;
	} rsp_t;

	// prefix flags handed from one cell to the next, covering all cells up to and
	// including the sender
	typedef struct packed {
		logic id_seen;
		logic gt_seen;
		logic blocked;
	} chain_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EVAL = 1'b1
	} state_t;

endpackage

// ----- design/djq_req_if.sv -----
// request channel of the job queue
// valid/ready handshake carrying djq_pkg::req_t
`timescale 1ns / 1ps

interface djq_req_if;
	logic          valid;
	logic          ready;
	djq_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/djq_rsp_if.sv -----
// result channel of the job queue
// valid/ready handshake carrying djq_pkg::rsp_t
`timescale 1ns / 1ps

interface djq_rsp_if;
	logic          valid;
	logic          ready;
	djq_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/djq_cell.sv -----
// one slot of the job queue: key, job id and the compare flags of the current request
// uses djq_pkg for request kinds and the chain bundle
`timescale 1ns / 1ps

module djq_cell #(
	parameter int KEY_W = 32
) (
	input  logic                clk,
	input  logic                load,
	input  logic                commit,
	input  djq_pkg::req_kind_t  kind,
	input  logic                valid,
	input  logic [KEY_W-1:0]    cmp_key,
	input  logic [7:0]          cmp_job,
	input  logic [KEY_W-1:0]    new_key,
	input  logic [7:0]          new_job,
	input  djq_pkg::chain_t     chain_in,
	output djq_pkg::chain_t     chain_out,
	input  logic                next_inr,
	output logic                inr,
	input  logic [KEY_W-1:0]    prev_key,
	input  logic [7:0]          prev_job,
	input  logic [KEY_W-1:0]    next_key,
	input  logic [7:0]          next_job,
	output logic [KEY_W-1:0]    key,
	output logic [7:0]          job
);
	import djq_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [7:0]       job_q;
	logic             gt_q;
	logic             ge_q;
	logic             idm_q;

	logic             is_p;
	logic             blk;
	logic             is_pos;
	logic [KEY_W-1:0] key_d;
	logic [7:0]       job_d;

	// flags against the request; an empty slot counts as larger than any key
	always_ff @(posedge clk) begin
		if (load) begin
			gt_q  <= !valid || (key_q > cmp_key);
			ge_q  <= !valid || (key_q >= cmp_key);
			idm_q <= valid && (job_q == cmp_job);
		end
		if (commit) begin
			key_q <= key_d;
			job_q <= job_d;
		end
	end

	// first id match and first slot past the new key
	assign is_p   = idm_q && !chain_in.id_seen;
	assign is_pos = gt_q && !chain_in.gt_seen;
	// range of an executed move: from the match up to the slot before the
	// first later key that is not smaller
	assign blk    = chain_in.blocked || (chain_in.id_seen && ge_q);
	assign inr    = is_p || (chain_in.id_seen && !blk);

	assign chain_out.id_seen = chain_in.id_seen || idm_q;
	assign chain_out.gt_seen = chain_in.gt_seen || gt_q;
	assign chain_out.blocked = blk;

	always_comb begin
		key_d = key_q;
		job_d = job_q;
		case (kind)
			REQ_ADD: begin
				if (is_pos) begin
					key_d = new_key;
					job_d = new_job;
				end else if (chain_in.gt_seen) begin
					key_d = prev_key;
					job_d = prev_job;
				end
			end
			REQ_CHECK: begin
				key_d = next_key;
				job_d = next_job;
			end
			REQ_EXEC: begin
				if (inr && next_inr) begin
					key_d = next_key;
					job_d = next_job;
				end else if (inr) begin
					key_d = new_key;
					job_d = new_job;
				end
			end
			REQ_REMOVE: begin
				if (is_p || chain_in.id_seen) begin
					key_d = next_key;
					job_d = next_job;
				end
			end
			default: begin
				key_d = key_q;
				job_d = job_q;
			end
		endcase
	end

	assign key = key_q;
	assign job = job_q;

endmodule

// ----- design/deadline_sorted_job_queue.sv -----
// Deadline sorted job queue. Every request passes through S_IDLE and S_EVAL: in the cycle
// it is accepted each cell compares its own key and job id with the request, and in S_EVAL
// the first-match and insertion positions ripple along the row of cells, every cell loads
// its own, its neighbor's or the new entry, and the result word goes to the output register.
// A new request is taken once the previous one has moved its result into that register, so
// a back-pressured result holds the queue in S_EVAL until the sink takes it. Keys are the
// low min(TIME_BITS, 32) bits of start_limit and now_time.
// top level: controller, fill count, output register and the row of djq_cell
// depends on djq_pkg, djq_req_if, djq_rsp_if, djq_cell
`timescale 1ns / 1ps

module deadline_sorted_job_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_BITS   = 32
) (
	input logic      clk,
	input logic      arst_n,
	djq_req_if.sink  req,
	djq_rsp_if.source rsp
);
	import djq_pkg::*;

	localparam int KEY_W  = (TIME_BITS < 32) ? TIME_BITS : 32;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	state_t           state_q;
	state_t           state_d;
	req_t             req_q;
	logic             hit_chk_q;
	logic [FILL_W-1:0] fill_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             commit;
	logic             cell_commit;
	logic             out_free;
	logic             full;
	logic             exec_hit;
	req_kind_t        kind;
	rsp_t             rsp_d;
	logic [KEY_W-1:0] cmp_key;
	logic [KEY_W-1:0] now_key;

	logic [KEY_W-1:0] key_w [QUEUE_DEPTH];
	logic [7:0]       job_w [QUEUE_DEPTH];
	logic             inr_w [QUEUE_DEPTH];
	chain_t           chain_w [QUEUE_DEPTH+1];

	assign cmp_key  = req.data.start_limit[KEY_W-1:0];
	assign now_key  = req.data.now_time[KEY_W-1:0];
	assign kind     = req_q.req_type;
	assign full     = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign out_free = !rsp_valid_q || rsp.ready;
	assign exec_hit = chain_w[QUEUE_DEPTH].id_seen;
	assign accept   = req.valid && req.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req.valid) state_d = S_EVAL;
			S_EVAL: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		req.ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_EVAL: commit = out_free;
			default: begin
				req.ready = 1'b0;
				commit    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req.data;
			hit_chk_q <= (fill_q != '0) && (key_w[0] < now_key);
		end
	end

	// cells only move when the request changes the queue
	always_comb begin
		cell_commit = commit;
		if (kind == REQ_ADD && full) cell_commit = 1'b0;
		if (kind == REQ_CHECK && !hit_chk_q) cell_commit = 1'b0;
	end

	always_comb begin
		rsp_d = '0;
		case (kind)
			REQ_ADD: rsp_d.overflow = full;
			REQ_CHECK: begin
				rsp_d.hit     = hit_chk_q;
				rsp_d.out_job = hit_chk_q ? job_w[0] : 8'd0;
			end
			REQ_EXEC, REQ_REMOVE: begin
				rsp_d.hit     = exec_hit;
				rsp_d.out_job = exec_hit ? req_q.job_id : 8'd0;
			end
			default: rsp_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cell_commit) begin
				case (kind)
					REQ_ADD: fill_q <= fill_q + 1'b1;
					REQ_CHECK: fill_q <= fill_q - 1'b1;
					REQ_REMOVE: if (exec_hit) fill_q <= fill_q - 1'b1;
					default: fill_q <= fill_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) rsp_q <= rsp_d;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign chain_w[0] = '0;

	for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
		logic [KEY_W-1:0] prev_key;
		logic [7:0]       prev_job;
		logic [KEY_W-1:0] next_key;
		logic [7:0]       next_job;
		logic             next_inr;

		if (j == 0) begin : g_head
			assign prev_key = key_w[j];
			assign prev_job = job_w[j];
		end else begin : g_mid
			assign prev_key = key_w[j-1];
			assign prev_job = job_w[j-1];
		end

		if (j == QUEUE_DEPTH - 1) begin : g_tail
			assign next_key = key_w[j];
			assign next_job = job_w[j];
			assign next_inr = 1'b0;
		end else begin : g_body
			assign next_key = key_w[j+1];
			assign next_job = job_w[j+1];
			assign next_inr = inr_w[j+1];
		end

		djq_cell #(
			.KEY_W (KEY_W)
		) u_cell (
			.clk       (clk),
			.load      (accept),
			.commit    (cell_commit),
			.kind      (kind),
			.valid     (FILL_W'(j) < fill_q),
			.cmp_key   (cmp_key),
			.cmp_job   (req.data.job_id),
			.new_key   (req_q.start_limit[KEY_W-1:0]),
			.new_job   (req_q.job_id),
			.chain_in  (chain_w[j]),
			.chain_out (chain_w[j+1]),
			.next_inr  (next_inr),
			.inr       (inr_w[j]),
			.prev_key  (prev_key),
			.prev_job  (prev_job),
			.next_key  (next_key),
			.next_job  (next_job),
			.key       (key_w[j]),
			.job       (job_w[j])
		);
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("fill count above queue depth");

	a_fill_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!cell_commit |=> $stable(fill_q))
		else $error("fill count moved without a commit");

	a_word_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid_q)
		else $error("result word missing after commit");

	a_no_hit_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.hit |-> rsp_q.out_job == 8'd0)
		else $error("job id without a hit");

	a_overflow_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.hit && rsp_q.overflow))
		else $error("hit and overflow together");

endmodule
